[rtl/core/lobe_pkg.sv]
package lobe_pkg;

    localparam int unsigned POOL = 64;
    localparam int unsigned LEVELS = 64;
    localparam int unsigned SLOT_AW = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int unsigned LEVEL_AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int unsigned CNT_W = $clog2(POOL + 1);
    localparam int unsigned LCNT_W = $clog2(POOL + 1);
    localparam int unsigned VOL_W = 38;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_DUP = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [31:0] order_id;
        logic        buy_side;
        logic [31:0] limit_price;
        logic [31:0] quantity;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic             bid_present;
        logic [31:0]      best_bid_price;
        logic [VOL_W-1:0] best_bid_volume;
        logic             ask_present;
        logic [31:0]      best_ask_price;
        logic [VOL_W-1:0] best_ask_volume;
        logic [6:0]       resting_count;
    } t_out_word;

    // search token handed from cell to cell along the order chain
    typedef struct packed {
        logic              hit;
        logic [SLOT_AW-1:0] hit_idx;
        logic              hit_buy;
        logic [31:0]       hit_price;
        logic [31:0]       hit_qty;
        logic              free;
        logic [SLOT_AW-1:0] free_idx;
    } t_slot_tok;

    // search token handed along a level chain
    typedef struct packed {
        logic               hit;
        logic [LEVEL_AW-1:0] hit_idx;
        logic               free;
        logic [LEVEL_AW-1:0] free_idx;
        logic               best;
        logic [31:0]        best_price;
        logic [VOL_W-1:0]   best_vol;
    } t_lvl_tok;

    // command broadcast to cells
    typedef struct packed {
        logic               wr;
        logic               clr;
        logic [SLOT_AW-1:0] idx;
        logic [31:0]        id;
        logic               buy;
        logic [31:0]        price;
        logic [31:0]        qty;
    } t_slot_cmd;

    typedef struct packed {
        logic                wr_new;
        logic                add;
        logic                sub;
        logic [LEVEL_AW-1:0] idx;
        logic [31:0]         price;
        logic [31:0]         qty;
    } t_lvl_cmd;

endpackage

[rtl/core/lobe_slot_cell.sv]
module lobe_slot_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lobe_pkg::SLOT_AW-1:0] i_my_idx,
    input  logic [31:0]                 i_key,
    input  lobe_pkg::t_slot_cmd         i_cmd,
    input  lobe_pkg::t_slot_tok         i_tok,
    output lobe_pkg::t_slot_tok         o_tok
);
    logic        r_used;
    logic [31:0] r_id;
    logic        r_buy;
    logic [31:0] r_price;
    logic [31:0] r_qty;
    lobe_pkg::t_slot_tok n_tok;

    // merge own entry into token: first hit and first free win
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && r_used && r_id == i_key) begin
            n_tok.hit = 1'b1;
            n_tok.hit_idx = i_my_idx;
            n_tok.hit_buy = r_buy;
            n_tok.hit_price = r_price;
            n_tok.hit_qty = r_qty;
        end
        if (!i_tok.free && !r_used) begin
            n_tok.free = 1'b1;
            n_tok.free_idx = i_my_idx;
        end
    end

    // token register toward next cell
    always_ff @(posedge i_clk) begin
        o_tok <= n_tok;
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.idx == i_my_idx) begin
            if (i_cmd.wr) begin
                r_used <= 1'b1;
            end else if (i_cmd.clr) begin
                r_used <= 1'b0;
            end
        end
        if (i_cmd.wr && i_cmd.idx == i_my_idx) begin
            r_id <= i_cmd.id;
            r_buy <= i_cmd.buy;
            r_price <= i_cmd.price;
            r_qty <= i_cmd.qty;
        end
    end
endmodule

[rtl/core/lobe_level_cell.sv]
module lobe_level_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_is_bid,
    input  logic [lobe_pkg::LEVEL_AW-1:0] i_my_idx,
    input  logic [31:0]                  i_key,
    input  lobe_pkg::t_lvl_cmd           i_cmd,
    input  lobe_pkg::t_lvl_tok           i_tok,
    output lobe_pkg::t_lvl_tok           o_tok
);
    logic                              r_used;
    logic [31:0]                       r_price;
    logic [lobe_pkg::VOL_W-1:0]        r_vol;
    logic [lobe_pkg::LCNT_W-1:0]       r_orders;
    lobe_pkg::t_lvl_tok                n_tok;
    logic                              sel;
    logic                              better;

    assign sel = (i_cmd.idx == i_my_idx);
    assign better = i_is_bid ? (r_price > i_tok.best_price) : (r_price < i_tok.best_price);

    // merge own level into token
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && r_used && r_price == i_key) begin
            n_tok.hit = 1'b1;
            n_tok.hit_idx = i_my_idx;
        end
        if (!i_tok.free && !r_used) begin
            n_tok.free = 1'b1;
            n_tok.free_idx = i_my_idx;
        end
        if (r_used && (!i_tok.best || better)) begin
            n_tok.best = 1'b1;
            n_tok.best_price = r_price;
            n_tok.best_vol = r_vol;
        end
    end

    always_ff @(posedge i_clk) begin
        o_tok <= n_tok;
    end

    // level update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (sel && i_cmd.wr_new) begin
            r_used <= 1'b1;
        end else if (sel && i_cmd.sub && r_orders <= lobe_pkg::LCNT_W'(1)) begin
            r_used <= 1'b0;
        end
        if (sel && i_cmd.wr_new) begin
            r_price <= i_cmd.price;
            r_vol <= lobe_pkg::VOL_W'(i_cmd.qty);
            r_orders <= lobe_pkg::LCNT_W'(1);
        end else if (sel && i_cmd.add) begin
            r_vol <= r_vol + lobe_pkg::VOL_W'(i_cmd.qty);
            r_orders <= r_orders + lobe_pkg::LCNT_W'(1);
        end else if (sel && i_cmd.sub) begin
            r_vol <= r_vol - lobe_pkg::VOL_W'(i_cmd.qty);
            if (r_orders != '0) begin
                r_orders <= r_orders - lobe_pkg::LCNT_W'(1);
            end
        end
    end
endmodule

[rtl/core/limit_order_book_engine_unit.sv]
// one word in flight: o_stall stays high while a word is being processed, so the next word
// is taken only after the result word has left, later while the output is stalled; the
// result waits on tokens rippling one cell a cycle down the order chain (id and free
// search) and then down both level chains (level search, then best-price scan)
// synchronous active-low reset empties the book; no clearing pass is needed
module limit_order_book_engine_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  lobe_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output lobe_pkg::t_out_word  o_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_SLOT, S_LVL, S_APPLY, S_BEST, S_OUT
    } t_state;

    localparam int unsigned NP = lobe_pkg::POOL;
    localparam int unsigned NL = lobe_pkg::LEVELS;
    localparam int unsigned CW = (NP > NL ? $clog2(NP + 1) : $clog2(NL + 1)) + 1;

    t_state                r_state;
    lobe_pkg::t_in_word    r_in;
    logic [CW-1:0]         r_cnt;
    lobe_pkg::t_slot_tok   r_stok;
    lobe_pkg::t_lvl_tok    r_ltok;
    logic [lobe_pkg::CNT_W-1:0] r_total;
    logic [1:0]            r_status;
    logic                  r_lvl_buy;
    logic [31:0]           r_lvl_price;

    lobe_pkg::t_slot_tok   stok [NP+1];
    lobe_pkg::t_lvl_tok    btok [NL+1];
    lobe_pkg::t_lvl_tok    atok [NL+1];
    lobe_pkg::t_slot_cmd   scmd;
    lobe_pkg::t_lvl_cmd    bcmd, acmd, lcmd;
    lobe_pkg::t_slot_tok   stok_zero;
    lobe_pkg::t_lvl_tok    ltok_zero;

    assign stok_zero = '0;
    assign ltok_zero = '0;
    assign stok[0] = stok_zero;
    assign btok[0] = ltok_zero;
    assign atok[0] = ltok_zero;

    // order chain
    for (genvar g = 0; g < NP; g++) begin : g_slot
        lobe_slot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_my_idx(lobe_pkg::SLOT_AW'(g)),
            .i_key   (r_in.order_id),
            .i_cmd   (scmd),
            .i_tok   (stok[g]),
            .o_tok   (stok[g+1])
        );
    end

    // bid and ask level chains
    for (genvar g = 0; g < NL; g++) begin : g_lvl
        lobe_level_cell u_bid (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_is_bid(1'b1),
            .i_my_idx(lobe_pkg::LEVEL_AW'(g)),
            .i_key   (r_lvl_price),
            .i_cmd   (bcmd),
            .i_tok   (btok[g]),
            .o_tok   (btok[g+1])
        );
        lobe_level_cell u_ask (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_is_bid(1'b0),
            .i_my_idx(lobe_pkg::LEVEL_AW'(g)),
            .i_key   (r_lvl_price),
            .i_cmd   (acmd),
            .i_tok   (atok[g]),
            .o_tok   (atok[g+1])
        );
    end

    // one-cycle update commands issued in apply state
    always_comb begin
        scmd = '0;
        lcmd = '0;
        scmd.idx = r_stok.free_idx;
        scmd.id = r_in.order_id;
        scmd.buy = r_in.buy_side;
        scmd.price = r_in.limit_price;
        scmd.qty = r_in.quantity;
        lcmd.price = r_lvl_price;
        lcmd.qty = (r_in.cmd == lobe_pkg::CMD_ADD) ? r_in.quantity : r_stok.hit_qty;
        lcmd.idx = r_ltok.hit ? r_ltok.hit_idx : r_ltok.free_idx;
        if (r_state == S_APPLY && r_status == lobe_pkg::ST_OK) begin
            if (r_in.cmd == lobe_pkg::CMD_ADD) begin
                if (r_ltok.hit || r_ltok.free) begin
                    scmd.wr = 1'b1;
                    lcmd.add = r_ltok.hit;
                    lcmd.wr_new = !r_ltok.hit;
                end
            end else begin
                scmd.clr = 1'b1;
                scmd.idx = r_stok.hit_idx;
                lcmd.sub = r_ltok.hit;
            end
        end
        bcmd = r_lvl_buy ? lcmd : lobe_pkg::t_lvl_cmd'('0);
        acmd = r_lvl_buy ? lobe_pkg::t_lvl_cmd'('0) : lcmd;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_cnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in <= i_data;
                        r_cnt <= '0;
                        r_state <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    if (r_cnt == CW'(NP)) begin
                        r_stok <= stok[NP];
                        r_cnt <= '0;
                        r_lvl_buy <= (r_in.cmd == lobe_pkg::CMD_ADD) ? r_in.buy_side
                                                                     : stok[NP].hit_buy;
                        r_lvl_price <= (r_in.cmd == lobe_pkg::CMD_ADD) ? r_in.limit_price
                                                                       : stok[NP].hit_price;
                        if (r_in.cmd == lobe_pkg::CMD_ADD) begin
                            if (stok[NP].hit) begin
                                r_status <= lobe_pkg::ST_DUP;
                            end else if (!stok[NP].free) begin
                                r_status <= lobe_pkg::ST_FULL;
                            end else begin
                                r_status <= lobe_pkg::ST_OK;
                            end
                        end else begin
                            r_status <= stok[NP].hit ? lobe_pkg::ST_OK
                                                     : lobe_pkg::ST_NOT_FOUND;
                        end
                        r_state <= S_LVL;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_LVL: begin
                    if (r_cnt == CW'(NL)) begin
                        r_ltok <= r_lvl_buy ? btok[NL] : atok[NL];
                        r_cnt <= '0;
                        r_state <= S_APPLY;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_APPLY: begin
                    if (r_status == lobe_pkg::ST_OK) begin
                        if (r_in.cmd == lobe_pkg::CMD_ADD) begin
                            if (r_ltok.hit || r_ltok.free) begin
                                r_total <= r_total + lobe_pkg::CNT_W'(1);
                            end else begin
                                r_status <= lobe_pkg::ST_FULL;
                            end
                        end else if (r_total != '0) begin
                            r_total <= r_total - lobe_pkg::CNT_W'(1);
                        end
                    end
                    r_state <= S_BEST;
                end
                S_BEST: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(NL)) begin
                        o_data.status <= r_status;
                        o_data.bid_present <= btok[NL].best;
                        o_data.best_bid_price <= btok[NL].best ? btok[NL].best_price : '0;
                        o_data.best_bid_volume <= btok[NL].best ? btok[NL].best_vol : '0;
                        o_data.ask_present <= atok[NL].best;
                        o_data.best_ask_price <= atok[NL].best ? atok[NL].best_price : '0;
                        o_data.best_ask_volume <= atok[NL].best ? atok[NL].best_vol : '0;
                        o_data.resting_count <= 7'(r_total);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
